[hdl/fpdf_pkg.sv]
// ----------------------------------------------------------------------------
// fpdf_pkg
// Types and constants for the fixed-point decimal formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpdf_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned BITS_W  = 5;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;

    localparam logic [IDX_W-1:0] REG_INT_DIGITS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAC_DIGITS  = 3'd1;
    localparam logic [IDX_W-1:0] REG_FILL_CHAR    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DECIMAL_CHAR = 3'd3;
    localparam logic [IDX_W-1:0] REG_SIGN_MODE    = 3'd4;

    typedef logic [3:0] t_digit;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT,
        ST_SEP
    } t_state;

endpackage

`default_nettype wire

[hdl/fixed_point_decimal_formatter_top.sv]
// Conversion: each accepted value runs through bit-serial binary-to-BCD conversion
//   in one shared add-3/shift unit before the first character slot.
// Occupancy: a value holds the block through the conversion, then one step per
//   digit, sign and separator position, longer while the output stalls.
// Reset: synchronous active-low; int 1, frac 0, fill 0, separator '.', no sign;
//   the block is idle and ready after reset.
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_top
// Formats a signed fixed-point value as decimal ASCII, one character per
// output request, using an iterative double-dabble converter.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_decimal_formatter_top
    import fpdf_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     i_cfg_we,
    input  wire logic [IDX_W-1:0]         i_cfg_idx,
    input  wire logic [CHAR_W-1:0]        i_cfg_data,

    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic signed [VALUE_W-1:0] i_value,

    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [CHAR_W-1:0]             o_char_code,
    output logic                          o_last_char,
    output logic [CNT_W-1:0]              o_nominal_width
);

    localparam int unsigned DIG_IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [CNT_W-1:0] MAX_D = CNT_W'(MAX_DIGITS);

    // configuration registers
    logic [CNT_W-1:0]  r_int_digits;
    logic [CNT_W-1:0]  r_frac_digits;
    logic [CHAR_W-1:0] r_fill_char;
    logic [CHAR_W-1:0] r_decimal_char;
    logic              r_sign_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_digits   <= 4'd1;
            r_frac_digits  <= 4'd0;
            r_fill_char    <= 8'd0;
            r_decimal_char <= 8'd46;
            r_sign_mode    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_INT_DIGITS:   r_int_digits   <= i_cfg_data[CNT_W-1:0];
                REG_FRAC_DIGITS:  r_frac_digits  <= i_cfg_data[CNT_W-1:0];
                REG_FILL_CHAR:    r_fill_char    <= i_cfg_data;
                REG_DECIMAL_CHAR: r_decimal_char <= i_cfg_data;
                REG_SIGN_MODE:    r_sign_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped digit counts
    logic [CNT_W-1:0] w_ni, w_nf, w_total, w_width;

    always_comb begin
        if (r_int_digits == 4'd0)
            w_ni = 4'd1;
        else if (r_int_digits > MAX_D)
            w_ni = MAX_D;
        else
            w_ni = r_int_digits;
        w_nf    = (r_frac_digits > MAX_D - w_ni) ? (MAX_D - w_ni) : r_frac_digits;
        w_total = w_ni + w_nf;
        w_width = w_total + {3'd0, (w_nf != 4'd0)} + {3'd0, r_sign_mode};
    end

    // sequencer and datapath registers
    t_state              r_state, n_state;
    logic [VALUE_W-1:0]  r_bin, n_bin;
    t_digit              r_bcd [MAX_DIGITS];
    t_digit              n_bcd [MAX_DIGITS];
    logic [BITS_W-1:0]   r_bits, n_bits;
    logic [DIG_IW-1:0]   r_idx, n_idx;
    logic                r_neg, n_neg;
    logic                r_started, n_started;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;
    logic [CNT_W-1:0]    r_width, n_width;

    // shared add-3 and shift unit
    t_digit w_adj [MAX_DIGITS];
    t_digit w_shf [MAX_DIGITS];

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        w_shf[0] = {w_adj[0][2:0], r_bin[VALUE_W-1]};
        for (int i = 1; i < MAX_DIGITS; i++) begin
            w_shf[i] = {w_adj[i][2:0], w_adj[i-1][3]};
        end
    end

    logic             w_slot;
    t_digit           w_dig;
    logic             w_now_started;
    logic             w_frac_side;
    logic [CNT_W-1:0] w_idx4;

    assign w_slot        = !r_out_valid || i_out_ready;
    assign w_dig         = r_bcd[r_idx];
    assign w_now_started = r_started || (w_dig != 4'd0);
    assign w_idx4        = CNT_W'(r_idx);
    assign w_frac_side   = (w_idx4 <= w_nf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_bits    <= n_bits;
        r_idx     <= n_idx;
        r_neg     <= n_neg;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
        r_width   <= n_width;
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_bits      = r_bits;
        n_idx       = r_idx;
        n_neg       = r_neg;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;
        n_width     = r_width;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_neg  = i_value[VALUE_W-1];
                    n_bin  = i_value[VALUE_W-1] ? VALUE_W'(-i_value) : VALUE_W'(i_value);
                    n_bits = '0;
                    for (int i = 0; i < MAX_DIGITS; i++) begin
                        n_bcd[i] = 4'd0;
                    end
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd  = w_shf;
                n_bin  = {r_bin[VALUE_W-2:0], 1'b0};
                n_bits = r_bits + 1'b1;
                if (r_bits == BITS_W'(VALUE_W - 1)) begin
                    n_idx     = DIG_IW'(w_total - 4'd1);
                    n_started = 1'b0;
                    n_state   = r_sign_mode ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = r_neg ? CHAR_MINUS : CHAR_PLUS;
                    n_last      = 1'b0;
                    n_width     = w_width;
                    n_state     = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (w_slot) begin
                    n_started = w_now_started;
                    if (w_frac_side || w_now_started || (r_fill_char != 8'd0)) begin
                        n_out_valid = 1'b1;
                        n_char      = (w_frac_side || w_now_started) ?
                                      (CHAR_ZERO + {4'd0, w_dig}) : r_fill_char;
                        n_last      = (r_idx == '0);
                        n_width     = w_width;
                    end
                    if ((w_idx4 == w_nf) && (w_nf != 4'd0)) begin
                        n_state = ST_SEP;
                    end else if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            ST_SEP: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_char      = r_decimal_char;
                    n_last      = 1'b0;
                    n_width     = w_width;
                    n_started   = 1'b1;
                    n_idx       = r_idx - 1'b1;
                    n_state     = ST_DIGIT;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_char_code     = r_char;
    assign o_last_char     = r_last;
    assign o_nominal_width = r_width;

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the decimal formatter: every accepted value is expanded into its
// expected character string, and each returned character is compared in
// order. Directed cases cover the register clamps, signs and separators.
// Random phases then sweep formats and values under random idling, bar the last.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import fpdf_pkg::*;

    localparam int unsigned NUM_DIGITS  = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PRINT_LIMIT = 40;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic [CNT_W-1:0]  width;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CHAR_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [VALUE_W-1:0] i_value;
    logic o_out_valid;
    logic i_out_ready;
    logic [CHAR_W-1:0] o_char_code;
    logic o_last_char;
    logic [CNT_W-1:0] o_nominal_width;

    // shadow of the format registers
    logic [3:0] fmt_int;
    logic [3:0] fmt_frac;
    logic [7:0] fmt_fill;
    logic [7:0] fmt_sep;
    logic       fmt_sign;

    t_text_char  pending_text[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;
    logic        steady      = 1'b0;

    fixed_point_decimal_formatter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_char_code     (o_char_code),
        .o_last_char     (o_last_char),
        .o_nominal_width (o_nominal_width)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] ten_pow(input int unsigned n);
        logic [63:0] p;
        p = 64'd1;
        for (int unsigned i = 0; i < n; i++) p = p * 64'd10;
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Appends the characters that one value should produce under the current format.
    task automatic format_value(input logic [31:0] value);
        logic [63:0] mag;
        logic [3:0]  digit;
        logic        neg;
        logic        started;
        int unsigned ni, nf, total, width;
        t_text_char  ch;
        neg = value[31];
        mag = neg ? (64'h1_0000_0000 - {32'd0, value}) : {32'd0, value};
        ni = 32'(fmt_int);
        nf = 32'(fmt_frac);
        if (ni < 1) ni = 1;
        if (ni > NUM_DIGITS) ni = NUM_DIGITS;
        if (nf > NUM_DIGITS - ni) nf = NUM_DIGITS - ni;
        total = ni + nf;
        mag = mag % ten_pow(total);
        width = total + (nf != 0 ? 1 : 0) + (fmt_sign ? 1 : 0);
        started = 1'b0;
        ch.last = 1'b0;
        ch.width = width[CNT_W-1:0];
        if (fmt_sign) begin
            ch.code = neg ? CHAR_MINUS : CHAR_PLUS;
            pending_text.push_back(ch);
        end
        for (int unsigned pos = 1; pos <= total; pos++) begin
            digit = 4'((mag / ten_pow(total - pos)) % 64'd10);
            if (digit != 0) started = 1'b1;
            if (pos >= ni || started) begin
                ch.code = CHAR_ZERO + CHAR_W'(digit);
                pending_text.push_back(ch);
            end else if (fmt_fill != 0) begin
                ch.code = fmt_fill;
                pending_text.push_back(ch);
            end
            if (pos == ni && nf != 0) begin
                ch.code = fmt_sep;
                pending_text.push_back(ch);
                started = 1'b1;
            end
        end
        pending_text[$].last = 1'b1;
    endtask

    task automatic send_value(input logic [31:0] value);
        int unsigned gap;
        gap = (!steady && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        format_value(value);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_text.size() != 0 || o_in_ready !== 1'b1);
    endtask

    task automatic set_format(input logic [7:0] int_d, input logic [7:0] frac_d,
                              input logic [7:0] fill, input logic [7:0] sep,
                              input logic [7:0] sign_d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_INT_DIGITS;
        i_cfg_data <= int_d;
        @(posedge i_clk);
        i_cfg_idx <= REG_FRAC_DIGITS;
        i_cfg_data <= frac_d;
        @(posedge i_clk);
        i_cfg_idx <= REG_FILL_CHAR;
        i_cfg_data <= fill;
        @(posedge i_clk);
        i_cfg_idx <= REG_DECIMAL_CHAR;
        i_cfg_data <= sep;
        @(posedge i_clk);
        i_cfg_idx <= REG_SIGN_MODE;
        i_cfg_data <= sign_d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fmt_int  = int_d[3:0];
        fmt_frac = frac_d[3:0];
        fmt_fill = fill;
        fmt_sep  = sep;
        fmt_sign = sign_d[0];
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        int unsigned total;
        total = 32'(fmt_int) + 32'(fmt_frac);
        if (total < 1) total = 1;
        if (total > NUM_DIGITS) total = NUM_DIGITS;
        case ($urandom_range(0, 6))
            0, 1: v = $urandom;
            2:    v = $urandom_range(0, 2000);
            3:    v = 32'(ten_pow($urandom_range(0, 9))) + 32'($urandom_range(0, 2)) - 32'd1;
            4:    v = 32'(ten_pow(total) * 64'($urandom_range(1, 3)));
            5:    v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: v = $urandom_range(0, 99);
        endcase
        if ($urandom_range(0, 1) && v != 32'h8000_0000) v = -v;
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_text.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h", o_char_code));
            end else begin
                want = pending_text.pop_front();
                if (o_char_code !== want.code)
                    report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                              o_char_code, want.code));
                if (o_last_char !== want.last)
                    report_mismatch($sformatf("last %b, want %b", o_last_char, want.last));
                if (o_nominal_width !== want.width)
                    report_mismatch($sformatf("width %0d, want %0d",
                                              o_nominal_width, want.width));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_reset_format();
        send_value(32'd0);
        send_value(32'd7);
        send_value(-32'sd12345);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        wait_idle();
    endtask

    task automatic test_full_width_signed();
        set_format(8'd10, 8'd0, 8'h00, "." , 8'd1);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        send_value(32'd0);
        send_value(32'hffff_ffff);
        wait_idle();
    endtask

    task automatic test_negative_zero();
        set_format(8'd3, 8'd0, "*", ".", 8'd1);
        send_value(-32'sd1000);
        send_value(32'd1000);
        wait_idle();
    endtask

    task automatic test_separator_fill();
        set_format(8'd3, 8'd3, 8'h00, ",", 8'd0);
        send_value(32'd5);
        send_value(-32'sd123456);
        wait_idle();
        set_format(8'd3, 8'd3, "#", "0", 8'd0);
        send_value(32'd5);
        send_value(32'd1230000);
        wait_idle();
    endtask

    task automatic test_digit_clamps();
        set_format(8'd0, 8'd0, 8'h00, ".", 8'd0);
        send_value(32'd42);
        wait_idle();
        set_format(8'd15, 8'd5, " ", ".", 8'd0);
        send_value(32'h8000_0000);
        wait_idle();
        set_format(8'd4, 8'd9, 8'h00, ".", 8'd0);
        send_value(32'd1234567890);
        wait_idle();
        set_format(8'd1, 8'd15, 8'h00, ".", 8'd1);
        send_value(32'hffff_ffff);
        wait_idle();
    endtask

    task automatic test_random_formats();
        logic [7:0] int_d, frac_d, fill, sep, sign_d;
        for (int phase = 0; phase < 8; phase++) begin
            int_d  = {4'($urandom), 4'($urandom_range(0, 15))};
            frac_d = {4'($urandom), 4'($urandom_range(0, 15))};
            fill   = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
            sep    = 8'($urandom_range(0, 255));
            sign_d = 8'($urandom_range(0, 255));
            case (phase)
                0: begin int_d = 8'd10; frac_d = 8'd0; end
                1: begin int_d = 8'd1; frac_d = 8'd9; fill = 8'hff; end
                2: begin int_d = 8'hf0; frac_d = 8'h0f; end
                default: ;
            endcase
            set_format(int_d, frac_d, fill, sep, sign_d);
            steady = (phase == 7);
            for (int n = 0; n < 12; n++) send_value(pick_value());
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_INT_DIGITS;
        i_cfg_data <= 8'd0;
        i_in_valid <= 1'b0;
        i_value <= 32'd0;
        i_out_ready <= 1'b0;
        fmt_int  = 4'd1;
        fmt_frac = 4'd0;
        fmt_fill = 8'h00;
        fmt_sep  = ".";
        fmt_sign = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_format();
        test_full_width_signed();
        test_negative_zero();
        test_separator_fill();
        test_digit_clamps();
        test_random_formats();

        repeat (60) @(posedge i_clk);
        if (pending_text.size() != 0)
            report_mismatch($sformatf("%0d chars never arrived", pending_text.size()));
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/fpdf_pkg.sv
hdl/fixed_point_decimal_formatter_top.sv
bench/tb_top.sv
